/* src/ppsli_pkg.sv */
`default_nettype none
package ppsli_pkg;

    localparam int FRAC_BITS = 16;

    localparam int NW = 18;
    localparam int PW = 32;
    localparam int TW = 31;

    // distance sum: three 50 bit products plus offset term
    localparam int SW = 53;
    // rounded distance width
    localparam int DW = SW - FRAC_BITS + 1;
    // dot product sum and its rounded value
    localparam int DOT2W = 38;
    localparam int DOTW = DOT2W - FRAC_BITS + 1;
    // dividend and quotient widths for lambda
    localparam int NUMW = DW + FRAC_BITS;
    localparam int QW = NUMW;
    localparam int LW = 47;
    localparam logic [LW-1:0] LAMBDA_LIMIT = LW'(64'sd1 <<< 45);

    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_TOLERANCE = 3'd4;

    localparam logic [1:0] SIDE_ON = 2'd0;
    localparam logic [1:0] SIDE_AHEAD = 2'd1;
    localparam logic [1:0] SIDE_BEHIND = 2'd2;

    localparam int IN_BYTES = 19;
    localparam int OUT_BYTES = 17;

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic signed [NW-1:0] nz;
        logic signed [PW-1:0] offset;
        logic [TW-1:0] eps;
    } plane_cfg_t;

    typedef struct packed {
        logic signed [PW-1:0] px;
        logic signed [PW-1:0] py;
        logic signed [PW-1:0] pz;
        logic signed [NW-1:0] dx;
        logic signed [NW-1:0] dy;
        logic signed [NW-1:0] dz;
    } query_t;

    typedef struct packed {
        logic signed [PW-1:0] distance;
        logic [1:0] side;
        logic hit;
        logic signed [PW-1:0] hx;
        logic signed [PW-1:0] hy;
        logic signed [PW-1:0] hz;
        logic ovf;
    } result_t;

    // round a sum with FRAC_BITS fraction bits, ties away from zero
    function automatic logic signed [DW-1:0] round_dist(input logic signed [SW-1:0] v);
        logic signed [SW:0] t;
        logic signed [SW:0] h;
        h = (SW+1)'(1) <<< (FRAC_BITS - 1);
        t = v[SW-1] ? ((SW+1)'(v) + h - (SW+1)'(1)) : ((SW+1)'(v) + h);
        round_dist = DW'(t >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DOTW-1:0] round_dot(input logic signed [DOT2W-1:0] v);
        logic signed [DOT2W:0] t;
        logic signed [DOT2W:0] h;
        h = (DOT2W+1)'(1) <<< (FRAC_BITS - 1);
        t = v[DOT2W-1] ? ((DOT2W+1)'(v) + h - (DOT2W+1)'(1)) : ((DOT2W+1)'(v) + h);
        round_dot = DOTW'(t >>> FRAC_BITS);
    endfunction

endpackage
`default_nettype wire

/* src/ppsli_divider.sv */
`default_nettype none
// pipelined restoring divider, one quotient bit per stage, magnitude in,
// rounded magnitude out: q = (a + b/2) / b
module ppsli_divider
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire logic [ppsli_pkg::NUMW-1:0] num,
    input  wire logic [ppsli_pkg::DOTW-1:0] den,
    output logic [ppsli_pkg::QW-1:0] quo
);
    localparam int N = ppsli_pkg::NUMW;
    localparam int B = ppsli_pkg::DOTW;

    logic [N-1:0] n_reg [0:N];
    logic [B-1:0] d_reg [0:N];
    logic [B:0] r_reg [0:N];
    logic [N-1:0] q_reg [0:N];

    always_comb
    begin
        n_reg[0] = num + N'(den >> 1);
        d_reg[0] = den;
        r_reg[0] = '0;
        q_reg[0] = '0;
    end

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [B+1:0] sh;
        logic [B+1:0] df;
        assign sh = {r_reg[s], n_reg[s][N-1-s]};
        assign df = sh - {2'b00, d_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1] <= n_reg[s];
                d_reg[s+1] <= d_reg[s];
                r_reg[s+1] <= df[B+1] ? sh[B:0] : df[B:0];
                q_reg[s+1] <= {q_reg[s][N-2:0], ~df[B+1]};
            end
        end
    end

    assign quo = q_reg[N];

    logic unused;
    assign unused = rst_n;
endmodule
`default_nettype wire

/* src/ppsli_core.sv */
`default_nettype none
// datapath: products, sums, rounding, divide, scale and saturate.
// all stages advance together on en; valid tracking is in the top level
module ppsli_core
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic en,
    input  wire ppsli_pkg::plane_cfg_t cfg,
    input  wire ppsli_pkg::query_t q,
    output ppsli_pkg::result_t res
);
    localparam int SW = ppsli_pkg::SW;
    localparam int DW = ppsli_pkg::DW;
    localparam int PW = ppsli_pkg::PW;
    localparam int NW = ppsli_pkg::NW;
    localparam int DOTW = ppsli_pkg::DOTW;
    localparam int DOT2W = ppsli_pkg::DOT2W;
    localparam int NUMW = ppsli_pkg::NUMW;
    localparam int QW = ppsli_pkg::QW;
    localparam int LW = ppsli_pkg::LW;
    localparam int FB = ppsli_pkg::FRAC_BITS;
    localparam int DLAT = NUMW;

    // stage 1: products
    ppsli_pkg::query_t q1_reg;
    logic signed [PW+NW-1:0] px1_reg, py1_reg, pz1_reg;
    logic signed [2*NW-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [PW-1:0] off1_reg;
    logic [ppsli_pkg::TW-1:0] eps1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_reg <= q;
            px1_reg <= q.px * cfg.nx;
            py1_reg <= q.py * cfg.ny;
            pz1_reg <= q.pz * cfg.nz;
            dx1_reg <= q.dx * cfg.nx;
            dy1_reg <= q.dy * cfg.ny;
            dz1_reg <= q.dz * cfg.nz;
            off1_reg <= cfg.offset;
            eps1_reg <= cfg.eps;
        end
    end

    // stage 2: sums and rounding
    ppsli_pkg::query_t q2_reg;
    logic signed [DW-1:0] dist2_reg;
    logic signed [DOTW-1:0] dot2_reg;
    logic [ppsli_pkg::TW-1:0] eps2_reg;
    logic signed [SW-1:0] s_dist;
    logic signed [DOT2W-1:0] s_dot;

    assign s_dist = SW'(px1_reg) + SW'(py1_reg) + SW'(pz1_reg) - (SW'(off1_reg) <<< FB);
    assign s_dot = DOT2W'(dx1_reg) + DOT2W'(dy1_reg) + DOT2W'(dz1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_reg <= q1_reg;
            dist2_reg <= ppsli_pkg::round_dist(s_dist);
            dot2_reg <= ppsli_pkg::round_dot(s_dot);
            eps2_reg <= eps1_reg;
        end
    end

    // stage 3: side, parallel test, saturate distance, divider operands
    logic signed [DW:0] eps_s;
    logic [DOTW-1:0] dot_mag;
    logic [DW-1:0] dist_mag;
    logic c_front, c_back, c_hit, c_dovf;
    logic signed [PW-1:0] c_sd;
    logic [1:0] c_side;

    assign eps_s = (DW+1)'(eps2_reg);
    assign dot_mag = dot2_reg[DOTW-1] ? DOTW'(-dot2_reg) : DOTW'(dot2_reg);
    assign dist_mag = dist2_reg[DW-1] ? DW'(-dist2_reg) : DW'(dist2_reg);
    assign c_front = (DW+1)'(dist2_reg) > eps_s;
    assign c_back = (DW+1)'(dist2_reg) < -eps_s;
    // compare at the full tolerance width
    assign c_hit = (dot2_reg != '0) && (ppsli_pkg::TW'(dot_mag) >= eps2_reg);

    always_comb
    begin
        c_side = c_front ? ppsli_pkg::SIDE_AHEAD :
                 c_back ? ppsli_pkg::SIDE_BEHIND : ppsli_pkg::SIDE_ON;
        c_dovf = 1'b0;
        c_sd = dist2_reg[PW-1:0];
        if (dist2_reg > DW'(32'sh7fffffff))
        begin
            c_sd = 32'sh7fffffff;
            c_dovf = 1'b1;
        end
        else if (dist2_reg < -DW'(33'sh80000000))
        begin
            c_sd = 32'sh80000000;
            c_dovf = 1'b1;
        end
    end

    // lambda = -dist*one/dot, sign is that of -dist xor dot
    typedef struct packed {
        ppsli_pkg::query_t q;
        logic signed [PW-1:0] sd;
        logic [1:0] side;
        logic hit;
        logic ovf;
        logic neg;
    } carry_t;

    carry_t c3;
    carry_t cd_reg [0:DLAT];
    logic [QW-1:0] quo;

    assign c3 = '{q: q2_reg, sd: c_sd, side: c_side, hit: c_hit, ovf: c_dovf,
                  neg: (dist2_reg[DW-1] == dot2_reg[DOTW-1]) && (dist2_reg != '0)};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cd_reg[0] <= c3;
        end
    end

    for (genvar s = 0; s < DLAT; s++) begin : g_carry
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd_reg[s+1] <= cd_reg[s];
            end
        end
    end

    logic [NUMW-1:0] div_num_reg;
    logic [DOTW-1:0] div_den_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_num_reg <= NUMW'(dist_mag) << FB;
            div_den_reg <= c_hit ? dot_mag : DOTW'(1);
        end
    end

    ppsli_divider u_div
    (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .num(div_num_reg),
        .den(div_den_reg),
        .quo(quo)
    );

    // clamp and sign lambda
    carry_t cl;
    logic signed [LW-1:0] lam_c;
    logic lam_ovf;
    assign cl = cd_reg[DLAT];

    always_comb
    begin
        lam_ovf = 1'b0;
        if (quo > QW'(ppsli_pkg::LAMBDA_LIMIT))
        begin
            lam_c = ppsli_pkg::LAMBDA_LIMIT;
            lam_ovf = 1'b1;
        end
        else
        begin
            lam_c = LW'(quo);
        end
        if (cl.neg)
        begin
            lam_c = -lam_c;
        end
    end

    carry_t c5_next;
    always_comb
    begin
        c5_next = cl;
        c5_next.ovf = cl.ovf | (cl.hit & lam_ovf);
    end

    carry_t c5_reg;
    logic signed [LW-1:0] lam5_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c5_reg <= c5_next;
            lam5_reg <= lam_c;
        end
    end

    // multiply d * lambda; 18 x 47 split into low and high halves
    localparam int LH = 24;
    carry_t c6_reg;
    logic signed [NW+LW-1:0] m_reg [0:2];
    logic signed [NW-1:0] dv [0:2];
    assign dv[0] = c5_reg.q.dx;
    assign dv[1] = c5_reg.q.dy;
    assign dv[2] = c5_reg.q.dz;
    logic signed [NW+LH:0] ml_reg [0:2];
    logic signed [NW+LW-LH-1:0] mh_reg [0:2];

    for (genvar i = 0; i < 3; i++) begin : g_mul
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ml_reg[i] <= dv[i] * $signed({1'b0, lam5_reg[LH-1:0]});
                mh_reg[i] <= dv[i] * $signed(lam5_reg[LW-1:LH]);
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[i] <= (NW+LW)'(ml_reg[i]) + ((NW+LW)'(mh_reg[i]) <<< LH);
            end
        end
    end

    carry_t c7_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c6_reg <= c5_reg;
            c7_reg <= c6_reg;
        end
    end

    // round, add point, saturate
    localparam int HW = NW + LW - FB + 2;
    logic signed [HW-1:0] hs [0:2];
    logic signed [PW-1:0] hv [0:2];
    logic hov [0:2];
    logic signed [PW-1:0] pv [0:2];
    assign pv[0] = c7_reg.q.px;
    assign pv[1] = c7_reg.q.py;
    assign pv[2] = c7_reg.q.pz;

    for (genvar i = 0; i < 3; i++) begin : g_hit
        logic signed [NW+LW:0] mt;
        assign mt = m_reg[i][NW+LW-1] ?
            ((NW+LW+1)'(m_reg[i]) + (NW+LW+1)'((1 << (FB-1)) - 1)) :
            ((NW+LW+1)'(m_reg[i]) + (NW+LW+1)'(1 << (FB-1)));
        assign hs[i] = HW'(mt >>> FB) + HW'(pv[i]);
        always_comb
        begin
            hov[i] = 1'b0;
            hv[i] = hs[i][PW-1:0];
            if (hs[i] > HW'(32'sh7fffffff))
            begin
                hv[i] = 32'sh7fffffff;
                hov[i] = 1'b1;
            end
            else if (hs[i] < -HW'(33'sh80000000))
            begin
                hv[i] = 32'sh80000000;
                hov[i] = 1'b1;
            end
        end
    end

    ppsli_pkg::result_t res_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.distance <= c7_reg.sd;
            res_reg.side <= c7_reg.side;
            res_reg.hit <= c7_reg.hit;
            res_reg.hx <= c7_reg.hit ? hv[0] : '0;
            res_reg.hy <= c7_reg.hit ? hv[1] : '0;
            res_reg.hz <= c7_reg.hit ? hv[2] : '0;
            res_reg.ovf <= c7_reg.ovf | (c7_reg.hit & (hov[0] | hov[1] | hov[2]));
        end
    end
    assign res = res_reg;
endmodule
`default_nettype wire

/* src/plane_point_side_and_line_intersect.sv */
`default_nettype none
// channel   dir  fields
// s_axis    in   tdata: point_x, point_y, point_z, dir_x, dir_y, dir_z
// m_axis    out  tdata: signed_distance, side, hit, hit_x, hit_y, hit_z, overflow
// cfg       in   cfg_we, cfg_addr, cfg_data
// one transfer per cycle while the skid register is empty; the pipeline depth
// is set mostly by the divider, one quotient bit per stage.
// reset clears the valid bits and sets the plane registers to their defaults only.
// a stall at the output loads the skid register; while it is full every
// stage freezes and s_axis_tready is low
module plane_point_side_and_line_intersect
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic s_axis_tready,
    // point_x, point_y, point_z, dir_x, dir_y, dir_z, zero pad
    input  wire logic [8*ppsli_pkg::IN_BYTES-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    // signed_distance, side, hit, hit_x, hit_y, hit_z, overflow, zero pad
    output logic [8*ppsli_pkg::OUT_BYTES-1:0] m_axis_tdata,
    input  wire logic cfg_we,
    input  wire logic [2:0] cfg_addr,
    input  wire logic [31:0] cfg_data
);
    localparam int LAT = 7 + ppsli_pkg::NUMW;

    ppsli_pkg::plane_cfg_t cfg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nx <= '0;
            cfg_reg.ny <= '0;
            cfg_reg.nz <= ppsli_pkg::NW'(1 << ppsli_pkg::FRAC_BITS);
            cfg_reg.offset <= '0;
            cfg_reg.eps <= ppsli_pkg::TW'(66);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ppsli_pkg::REG_NORMAL_X: cfg_reg.nx <= cfg_data[ppsli_pkg::NW-1:0];
                ppsli_pkg::REG_NORMAL_Y: cfg_reg.ny <= cfg_data[ppsli_pkg::NW-1:0];
                ppsli_pkg::REG_NORMAL_Z: cfg_reg.nz <= cfg_data[ppsli_pkg::NW-1:0];
                ppsli_pkg::REG_OFFSET: cfg_reg.offset <= cfg_data;
                ppsli_pkg::REG_TOLERANCE: cfg_reg.eps <= cfg_data[ppsli_pkg::TW-1:0];
                default: ;
            endcase
        end
    end

    ppsli_pkg::query_t q;
    assign q.px = s_axis_tdata[31:0];
    assign q.py = s_axis_tdata[63:32];
    assign q.pz = s_axis_tdata[95:64];
    assign q.dx = s_axis_tdata[113:96];
    assign q.dy = s_axis_tdata[131:114];
    assign q.dz = s_axis_tdata[149:132];

    // pipeline advances whenever the skid register is empty
    logic en;
    logic [LAT-1:0] v_reg;
    logic skid_v_reg;
    ppsli_pkg::result_t skid_reg;
    ppsli_pkg::result_t res;
    logic out_v;
    ppsli_pkg::result_t out_r;

    assign en = !skid_v_reg;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    ppsli_core u_core
    (
        .clk(clk),
        .rst_n(rst_n),
        .en(en),
        .cfg(cfg_reg),
        .q(q),
        .res(res)
    );

    // skid catches the pipeline head when the output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
        end
        else if (!skid_v_reg)
        begin
            skid_v_reg <= v_reg[LAT-1] && !m_axis_tready;
        end
        else if (m_axis_tready)
        begin
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_reg <= res;
        end
    end

    assign out_v = skid_v_reg || v_reg[LAT-1];
    assign out_r = skid_v_reg ? skid_reg : res;
    assign m_axis_tvalid = out_v;
    assign m_axis_tdata = {4'd0, out_r.ovf, out_r.hz, out_r.hy, out_r.hx,
                           out_r.hit, out_r.side, out_r.distance};
endmodule
`default_nettype wire

/* src/ppsli_checker.sv */
`default_nettype none
module ppsli_checker
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [135:0] m_axis_tdata
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
        else $error("bad side code");
    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[34] |-> m_axis_tdata[130:35] == '0)
        else $error("hit coords nonzero without hit");
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("input stalled though output drained");
endmodule

bind plane_point_side_and_line_intersect ppsli_checker u_chk
(
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
